// ----- hw/rtl/qsl_pkg.sv -----
package qsl_pkg;

  localparam int MAX_ITEMS_DEF   = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // per-cycle command shared by every cell of the chain
  typedef struct packed {
    logic insert;  // place new value; entries after it move one cell right
    logic shift;   // move every entry one cell left toward the output
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/qsl_if.sv -----
interface qsl_in_if #(
  parameter int VALUE_WIDTH = qsl_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface qsl_out_if #(
  parameter int VALUE_WIDTH = qsl_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sorted_value;
  logic                          last_result;
  logic                          overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflow, output ready);
endinterface

// ----- hw/rtl/qsl_cell.sv -----
module qsl_cell #(
  parameter int VALUE_WIDTH = qsl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qsl_pkg::cell_ctrl_t           ctrl,
  input  logic                          descending,
  input  logic signed [VALUE_WIDTH-1:0] new_value,
  input  logic                          left_take,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic                          left_valid,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  input  logic                          right_valid,
  output logic                          take,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          valid
);

  logic signed [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                          valid_r, valid_nxt;
  logic                          ahead;

  // new value goes ahead of this entry; equal values stay behind
  assign ahead = descending ? (new_value > value_r) : (new_value < value_r);
  assign take  = !valid_r || ahead;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.insert && take) begin
      if (left_take) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// ----- hw/rtl/quicksort_lomuto.sv -----
// the first result is shown in the cycle after the last item is taken
// throughput: one item per cycle while loading, one result per cycle out while
//   out_if.ready is high; a new set is taken only after the last one has fully
//   drained, as in_if.ready stays low until the final result is taken
// reset: rst_n synchronous active low; empties the chain, clears the count,
//   the dropped flag and the order register (ascending)
module quicksort_lomuto #(
  parameter int MAX_ITEMS   = qsl_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = qsl_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qsl_in_if.sink    in_if,
  qsl_out_if.source out_if,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // two phases: collecting items, then draining the sorted chain
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             descending_r;

  logic                 in_fire, out_fire, full;
  qsl_pkg::cell_ctrl_t  ctrl;

  // chain taps, one per cell
  logic                          take  [MAX_ITEMS];
  logic signed [VALUE_WIDTH-1:0] value [MAX_ITEMS];
  logic                          valid [MAX_ITEMS];

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign full     = (count_r == CNT_W'(MAX_ITEMS));

  // items past capacity are dropped, the last one still closes the set
  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_if.last_item) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            // set done, next item starts a fresh one
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      dropped_r    <= 1'b0;
      descending_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      if (cfg_we) begin
        descending_r <= cfg_wdata;
      end
    end
  end

  // sorted chain: cell 0 always holds the next value to go out
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                          l_take, l_valid, r_valid;
    logic signed [VALUE_WIDTH-1:0] l_value, r_value;

    if (i == 0) begin : g_head
      assign l_take  = 1'b0;
      assign l_value = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_take  = take[i-1];
      assign l_value = value[i-1];
      assign l_valid = valid[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_value = value[i+1];
      assign r_valid = valid[i+1];
    end

    qsl_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .descending  (descending_r),
      .new_value   (in_if.value),
      .left_take   (l_take),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .right_value (r_value),
      .right_valid (r_valid),
      .take        (take[i]),
      .value       (value[i]),
      .valid       (valid[i])
    );
  end

  assign in_if.ready = (state_r == ST_LOAD);

  // result comes straight from the head cell register
  assign out_if.valid        = (state_r == ST_EMIT);
  assign out_if.sorted_value = value[0];
  assign out_if.last_result  = (count_r == CNT_W'(1));
  assign out_if.overflow     = dropped_r;

endmodule

// ----- hw/rtl/qsl_checker.sv -----
module qsl_checker #(
  parameter int VALUE_WIDTH = qsl_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last_item,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_sorted_value,
  input logic                   out_last_result,
  input logic                   out_overflow
);

  // no item taken while a set is being drained
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input ready while results pending");

  // a closing item starts the results on the next cycle
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_item |=> out_valid)
    else $error("no result after last item");

  // final result hands control back to loading
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> !out_valid && in_ready)
    else $error("block did not return to loading");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sorted_value) && $stable(out_last_result)
      && $stable(out_overflow))
    else $error("result changed while stalled");

endmodule

bind quicksort_lomuto qsl_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_qsl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_last_item     (in_if.last_item),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_sorted_value (out_if.sorted_value),
  .out_last_result  (out_if.last_result),
  .out_overflow     (out_if.overflow)
);

// ----- bench/quicksort_lomuto_tb.sv -----
module quicksort_lomuto_tb;

  localparam int CAPACITY   = qsl_pkg::MAX_ITEMS_DEF;
  localparam int VW         = qsl_pkg::VALUE_WIDTH_DEF;
  localparam int STACK_SIZE = CAPACITY + 2;
  // the block answers in the cycle after the last item; leave a wide margin
  localparam int SETTLE     = 12;
  localparam int CYCLE_CAP  = 400000;

  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

  localparam bit ORDER_ASC  = 1'b0;
  localparam bit ORDER_DESC = 1'b1;

  typedef struct {
    logic signed [VW-1:0] value;
    bit                   last_result;
    bit                   overflow;
  } sorted_entry_t;

  // one row of the directed table; typed rows carry the answer of a set of one
  typedef struct {
    logic signed [VW-1:0] value;
    bit                   last_item;
    bit                   typed;
    logic signed [VW-1:0] want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  qsl_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  qsl_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  quicksort_lomuto #(
    .MAX_ITEMS  (CAPACITY),
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the block: element buffer, fill count, drop flag, sort order
  logic signed [VW-1:0] held_vals [CAPACITY];
  int                   held_count;
  bit                   held_dropped;
  bit                   order_desc;

  // sorted values still owed by the block, oldest first
  sorted_entry_t sorted_due [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_ok;
  int  stall_left = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // sort shadow: lomuto partition, last element as pivot, explicit stack
  // ---------------------------------------------------------------------

  function automatic bit precedes(logic signed [VW-1:0] a, logic signed [VW-1:0] b);
    return order_desc ? (a > b) : (a < b);
  endfunction

  function automatic void swap_held(int i, int j);
    logic signed [VW-1:0] t;
    t            = held_vals[i];
    held_vals[i] = held_vals[j];
    held_vals[j] = t;
  endfunction

  // partition [lo, hi), returns the final slot of the pivot
  function automatic int partition_held(int lo, int hi);
    int                   piv;
    int                   fill;
    logic signed [VW-1:0] pivot;
    piv   = hi - 1;
    pivot = held_vals[piv];
    fill  = lo;
    for (int i = lo; i < piv; i++) begin
      if (precedes(held_vals[i], pivot)) begin
        swap_held(fill, i);
        fill++;
      end
    end
    swap_held(piv, fill);
    return fill;
  endfunction

  function automatic void sort_held();
    int lo_stack [STACK_SIZE];
    int hi_stack [STACK_SIZE];
    int depth;
    int lo;
    int hi;
    int p;
    depth       = 1;
    lo_stack[0] = 0;
    hi_stack[0] = held_count;
    while (depth > 0) begin
      depth--;
      lo = lo_stack[depth];
      hi = hi_stack[depth];
      while (hi - lo > 1) begin
        p = partition_held(lo, hi);
        // park the larger side, keep working on the smaller one
        if (p - lo > hi - (p + 1)) begin
          if (depth < STACK_SIZE) begin
            lo_stack[depth] = lo;
            hi_stack[depth] = p;
            depth++;
          end
          lo = p + 1;
        end else begin
          if (depth < STACK_SIZE) begin
            lo_stack[depth] = p + 1;
            hi_stack[depth] = hi;
            depth++;
          end
          hi = p;
        end
      end
    end
  endfunction

  // append one owed result at the tail of the queue
  function automatic void owe_result(sorted_entry_t e);
    sorted_due.insert(sorted_due.size(), e);
  endfunction

  // take one accepted item into the shadow; a last item releases the set
  function automatic void absorb_item(logic signed [VW-1:0] v, bit last);
    sorted_entry_t e;
    if (held_count < CAPACITY) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;
    sort_held();
    for (int k = 0; k < held_count; k++) begin
      e.value       = held_vals[k];
      e.last_result = (k + 1 == held_count);
      e.overflow    = held_dropped;
      owe_result(e);
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // result side: random stall bursts on ready, field-by-field compare
  // ---------------------------------------------------------------------

  function automatic void note_mismatch(string field, logic signed [VW-1:0] want,
                                        logic signed [VW-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d (0x%h), got %0d (0x%h)",
               field, want, want, got, got);
  endfunction

  always @(posedge clk) begin
    sorted_entry_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item out: value %0d last %b overflow %b",
                   out_ch.sorted_value, out_ch.last_result, out_ch.overflow);
      end else begin
        e = sorted_due.pop_front();
        if (out_ch.sorted_value !== e.value)
          note_mismatch("sorted_value", e.value, out_ch.sorted_value);
        if (out_ch.last_result !== e.last_result)
          note_mismatch("last_result", e.last_result, out_ch.last_result);
        if (out_ch.overflow !== e.overflow)
          note_mismatch("overflow", e.overflow, out_ch.overflow);
      end
    end
    // ready: either counting down a stall burst, maybe starting one, or high
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_ok && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // present one item and hold it until taken;
  // valid stays high into the next item when no gap is drawn
  task automatic send_item(logic signed [VW-1:0] v, bit last, output bit taken_last);
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.last_item <= last;
    do @(posedge clk); while (!in_ch.ready);
    taken_last = last;
  endtask

  // after an item is taken, maybe idle for a burst
  task automatic idle_gap();
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every owed result come back, plus a settle margin
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_order(bit d);
    drain_results();
    cfg_wdata <= d;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    order_desc = d;
  endtask

  // mostly full-range values, with extremes and a narrow band for duplicates
  function automatic logic signed [VW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n);
    bit done;
    for (int i = 0; i < n; i++) begin
      send_item(pick_value(), i == n - 1, done);
      absorb_item(in_ch.value, done);
      idle_gap();
    end
  endtask

  // directed rows: single-item sets have their answer typed in
  stim_row_t directed [] = '{
    '{VAL_MIN,        1'b1, 1'b1, VAL_MIN},
    '{VAL_MAX,        1'b1, 1'b1, VAL_MAX},
    '{32'sd0,         1'b1, 1'b1, 32'sd0},
    '{-32'sd1,        1'b1, 1'b1, -32'sd1},
    // two items, out of order
    '{32'sd5,         1'b0, 1'b0, 32'sd0},
    '{-32'sd5,        1'b1, 1'b0, 32'sd0},
    // extremes and neighbors of zero mixed
    '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
    '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
    '{-32'sd1,        1'b0, 1'b0, 32'sd0},
    '{32'sd1,         1'b0, 1'b0, 32'sd0},
    '{32'sd0,         1'b1, 1'b0, 32'sd0},
    // all equal
    '{32'sd7,         1'b0, 1'b0, 32'sd0},
    '{32'sd7,         1'b0, 1'b0, 32'sd0},
    '{32'sd7,         1'b1, 1'b0, 32'sd0},
    // already in order, then reversed
    '{32'sd1,         1'b0, 1'b0, 32'sd0},
    '{32'sd2,         1'b0, 1'b0, 32'sd0},
    '{32'sd3,         1'b1, 1'b0, 32'sd0},
    '{32'sd3,         1'b0, 1'b0, 32'sd0},
    '{32'sd2,         1'b0, 1'b0, 32'sd0},
    '{32'sd1,         1'b1, 1'b0, 32'sd0}
  };

  initial begin
    sorted_entry_t typed_e;
    bit            done;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.last_item <= 1'b0;
    idle_ok      = 1'b1;
    held_count   = 0;
    held_dropped = 1'b0;
    order_desc   = ORDER_ASC;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, ascending
    set_order(ORDER_ASC);
    foreach (directed[r]) begin
      send_item(directed[r].value, directed[r].last_item, done);
      if (directed[r].typed) begin
        // a set of one comes straight back, no overflow
        typed_e.value       = directed[r].want;
        typed_e.last_result = 1'b1;
        typed_e.overflow    = 1'b0;
        owe_result(typed_e);
      end else begin
        absorb_item(directed[r].value, done);
      end
      idle_gap();
    end

    // random part: four order phases, the last one without idling
    for (int phase = 0; phase < 4; phase++) begin
      set_order(phase[0] ? ORDER_ASC : ORDER_DESC);
      for (int s = 0; s < 2; s++) begin
        idle_ok = (phase < 3) && ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0)
          send_set($urandom_range(11, 30));
        else
          send_set($urandom_range(1, 10));
        // hold the sender until the block has caught up
        if (phase == 0 && s == 1)
          drain_results();
      end
      // a completely full buffer, then one that spills two items,
      // the last of them included
      if (phase == 1)
        send_set(CAPACITY);
      if (phase == 2)
        send_set(CAPACITY + 2);
    end
    idle_ok = 1'b0;

    drain_results();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/qsl_pkg.sv
hw/rtl/qsl_if.sv
hw/rtl/qsl_cell.sv
hw/rtl/quicksort_lomuto.sv
hw/rtl/qsl_checker.sv
bench/quicksort_lomuto_tb.sv
